// ===== rtl/decode_hazard_scoreboard_defines.svh =====
// Assertion macros shared by the decode hazard scoreboard RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef DECODE_HAZARD_SCOREBOARD_DEFINES_SVH
`define DECODE_HAZARD_SCOREBOARD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decode hazard scoreboard: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decode hazard scoreboard: next-cycle check failed");

`endif

// ===== rtl/dhs_pkg.sv =====
// Types and constants for the decode hazard scoreboard.
// No dependencies; used by dhs_scoreboard and decode_hazard_scoreboard.
package dhs_pkg;

    typedef logic [1:0] dhs_wait_t;
    typedef logic [5:0] dhs_src_t;

    localparam dhs_wait_t WAIT_STALL  = 2'd1;
    localparam dhs_wait_t WAIT_BYPASS = 2'd2;

    localparam dhs_src_t REG_NONE = 6'd0;
    localparam dhs_src_t REG_HI   = 6'd32;
    localparam dhs_src_t REG_LO   = 6'd33;

    typedef struct packed {
        logic [5:0] src_a;
        logic [5:0] src_b;
        logic       float_src_valid;
        logic [3:0] float_src;
        logic       is_illegal;
        logic       is_syscall;
        logic       writes_gpr;
        logic [1:0] hilo_write;
        logic       writes_fpr;
        logic [4:0] dest_reg;
        logic [1:0] result_latency;
        logic       syscall_done;
    } dhs_item_t;

    typedef struct packed {
        logic stall_res;
        logic bubble;
        logic squash_fetch;
        logic illegal;
        logic src_a_bypass;
        logic src_b_bypass;
    } dhs_result_t;

    // One step of a wait counter: optional clear on bypass, count down,
    // then raise to the result latency.
    function automatic dhs_wait_t wait_step(input dhs_wait_t cur, input logic clr,
                                            input logic adv, input logic raise,
                                            input dhs_wait_t lat);
        dhs_wait_t v;
        v = clr ? 2'd0 : cur;
        if (adv && (v != 2'd0)) begin
            v = v - 2'd1;
        end
        if (raise && (lat > v)) begin
            v = lat;
        end
        return v;
    endfunction

endpackage

// ===== rtl/dhs_scoreboard.sv =====
// Wait counters, syscall flag and the per-instruction interlock decision.
// Depends on dhs_pkg and decode_hazard_scoreboard_defines.svh.
`include "decode_hazard_scoreboard_defines.svh"

module dhs_scoreboard
    import dhs_pkg::*;
#(
    parameter int NUM_GPR       = 32,
    parameter int NUM_FPR_PAIRS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  dhs_item_t   item,
    output dhs_result_t result
);

    logic [NUM_GPR-1:0][1:0]       gpr_wait_reg, gpr_wait_next;
    logic [NUM_FPR_PAIRS-1:0][1:0] fpr_wait_reg, fpr_wait_next;
    dhs_wait_t                     hi_wait_reg, hi_wait_next;
    dhs_wait_t                     lo_wait_reg, lo_wait_next;
    logic                          syscall_pending_reg, syscall_pending_next;

    logic      pend, path_ill, path_sys, path_norm;
    logic      a_hit, b_hit, f_busy, hazard, stall, issue, adv;
    dhs_wait_t a_val, b_val;
    logic      byp_a, byp_b, wr_gpr_sel, wr_hilo_sel, wr_fpr_sel;

    assign pend      = syscall_pending_reg && !item.syscall_done;
    assign path_ill  = !pend && item.is_illegal;
    assign path_sys  = !pend && !item.is_illegal && item.is_syscall;
    assign path_norm = !pend && !item.is_illegal && !item.is_syscall;

    // Source lookups: HI and LO codes always win over a general register.
    always_comb
    begin
        a_hit = 1'b0;
        a_val = 2'd0;
        b_hit = 1'b0;
        b_val = 2'd0;
        if (item.src_a == REG_HI)
        begin
            a_hit = 1'b1;
            a_val = hi_wait_reg;
        end
        else if (item.src_a == REG_LO)
        begin
            a_hit = 1'b1;
            a_val = lo_wait_reg;
        end
        if (item.src_b == REG_HI)
        begin
            b_hit = 1'b1;
            b_val = hi_wait_reg;
        end
        else if (item.src_b == REG_LO)
        begin
            b_hit = 1'b1;
            b_val = lo_wait_reg;
        end
        for (int i = 1; i < NUM_GPR; i++)
        begin
            if ((i != 32) && (i != 33))
            begin
                if (item.src_a == 6'(i))
                begin
                    a_hit = 1'b1;
                    a_val = gpr_wait_reg[i];
                end
                if (item.src_b == 6'(i))
                begin
                    b_hit = 1'b1;
                    b_val = gpr_wait_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        f_busy = 1'b0;
        for (int j = 0; j < NUM_FPR_PAIRS; j++)
        begin
            if (item.float_src_valid && ({1'b0, item.float_src} == 5'(j))
                && (fpr_wait_reg[j] != 2'd0))
            begin
                f_busy = 1'b1;
            end
        end
    end

    assign hazard = (a_hit && (a_val == WAIT_STALL)) || (b_hit && (b_val == WAIT_STALL))
                    || f_busy;
    assign stall  = pend || path_sys || (path_norm && hazard);
    assign issue  = path_norm && !hazard;
    assign adv    = !path_ill;
    assign byp_a  = issue && a_hit && (a_val == WAIT_BYPASS);
    assign byp_b  = issue && b_hit && (b_val == WAIT_BYPASS);

    // Destination priority: general register, then HI/LO, then float pair.
    assign wr_gpr_sel  = issue && item.writes_gpr && (item.dest_reg != 5'd0);
    assign wr_hilo_sel = issue && !wr_gpr_sel && (item.hilo_write != 2'd0);
    assign wr_fpr_sel  = issue && !wr_gpr_sel && (item.hilo_write == 2'd0)
                         && item.writes_fpr;

    always_comb
    begin
        logic clr;
        for (int i = 0; i < NUM_GPR; i++)
        begin
            clr = ((i != 32) && (i != 33) && (i != 0)) &&
                  ((byp_a && (item.src_a == 6'(i))) || (byp_b && (item.src_b == 6'(i))));
            gpr_wait_next[i] = wait_step(gpr_wait_reg[i], clr, adv,
                                         wr_gpr_sel && ({1'b0, item.dest_reg} == 6'(i)),
                                         item.result_latency);
        end
        for (int j = 0; j < NUM_FPR_PAIRS; j++)
        begin
            fpr_wait_next[j] = wait_step(fpr_wait_reg[j], 1'b0, adv,
                                         wr_fpr_sel && ({1'b0, item.dest_reg[4:1]} == 5'(j)),
                                         item.result_latency);
        end
        hi_wait_next = wait_step(hi_wait_reg,
                                 (byp_a && (item.src_a == REG_HI))
                                 || (byp_b && (item.src_b == REG_HI)),
                                 adv, wr_hilo_sel && item.hilo_write[0],
                                 item.result_latency);
        lo_wait_next = wait_step(lo_wait_reg,
                                 (byp_a && (item.src_a == REG_LO))
                                 || (byp_b && (item.src_b == REG_LO)),
                                 adv, wr_hilo_sel && item.hilo_write[1],
                                 item.result_latency);
        syscall_pending_next = pend || path_sys;
    end

    always_comb
    begin
        result.stall_res    = stall;
        result.bubble       = stall;
        result.squash_fetch = pend || path_sys;
        result.illegal      = path_ill;
        result.src_a_bypass = byp_a;
        result.src_b_bypass = byp_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_wait_reg        <= '0;
            fpr_wait_reg        <= '0;
            hi_wait_reg         <= 2'd0;
            lo_wait_reg         <= 2'd0;
            syscall_pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            gpr_wait_reg        <= gpr_wait_next;
            fpr_wait_reg        <= fpr_wait_next;
            hi_wait_reg         <= hi_wait_next;
            lo_wait_reg         <= lo_wait_next;
            syscall_pending_reg <= syscall_pending_next;
        end
    end

    // Scoreboard state moves only when an instruction is evaluated.
    `DHS_ASSERT_NEXT(a_state_holds_idle, !fire, $stable(gpr_wait_reg) && $stable(fpr_wait_reg))
    // An illegal op with no syscall in flight leaves every counter alone.
    `DHS_ASSERT_NEXT(a_illegal_no_change, fire && path_ill,
                     $stable(gpr_wait_reg) && $stable(hi_wait_reg) && $stable(lo_wait_reg))
    // A new syscall always leaves the pending flag set.
    `DHS_ASSERT_NEXT(a_syscall_sets_pending, fire && path_sys, syscall_pending_reg)

endmodule

// ===== rtl/decode_hazard_scoreboard.sv =====
// Decode hazard scoreboard: interlock, bypass select and syscall squash for decode.
// An item is held in the input register, then its decision is registered in the result register.
// Throughput is one instruction per cycle while res_stall is low; the counter update sets this single pass.
// Reset (rst_n low, asynchronous) clears all wait counters, the syscall flag and valids.
// Depends on dhs_pkg, dhs_scoreboard and decode_hazard_scoreboard_defines.svh.
`include "decode_hazard_scoreboard_defines.svh"

module decode_hazard_scoreboard
    import dhs_pkg::*;
#(
    parameter int NUM_GPR       = 32,
    parameter int NUM_FPR_PAIRS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  dhs_item_t   item,
    output logic        res_valid,
    input  logic        res_stall,
    output dhs_result_t res
);

    // The input register holds one accepted beat. It is evaluated against the
    // scoreboard as soon as the result register is free or being drained, so a
    // beat can be taken every cycle and one more can be held while a result
    // waits downstream.
    logic        in_valid_reg, in_valid_next;
    dhs_item_t   in_data_reg;
    logic        res_valid_reg, res_valid_next;
    dhs_result_t res_data_reg;
    dhs_result_t decide;
    logic        fire, accept;

    assign fire       = in_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = in_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    // All counters and the syscall flag advance only when fire is high, so
    // stalls on either side never age the scoreboard.
    dhs_scoreboard #(
        .NUM_GPR       (NUM_GPR),
        .NUM_FPR_PAIRS (NUM_FPR_PAIRS)
    ) u_scoreboard (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data_reg),
        .result (decide)
    );

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers carry no reset; their valids qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= item;
        end
        if (fire)
        begin
            res_data_reg <= decide;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

    // A bypassed source only happens on an instruction that issued.
    `DHS_ASSERT_NOW(a_bypass_needs_issue,
                    res_valid && (res.src_a_bypass || res.src_b_bypass), !res.stall_res)
    // An illegal op is passed on with every other flag low.
    `DHS_ASSERT_NOW(a_illegal_alone, res_valid && res.illegal,
                    !res.stall_res && !res.squash_fetch && !res.bubble)
    // A syscall squash always comes with a stall and a bubble.
    `DHS_ASSERT_NOW(a_squash_stalls, res_valid && res.squash_fetch,
                    res.stall_res && res.bubble)

endmodule
